### design/quaternion_vector_rotate_core_macros.svh
// assertion macros used by the checker file
`ifndef QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define QVR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qvr check failed");

// next-cycle implication, checked out of reset
`define QVR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qvr check failed");

`endif

### design/qvr_pkg.sv
package qvr_pkg;

  // one input request, field by field
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } in_t;

  // first-level results handed to the wide multiplier stages
  typedef struct packed {
    logic signed [64:0] c_x;     // u x v, 46 fraction bits
    logic signed [64:0] c_y;
    logic signed [64:0] c_z;
    logic signed [65:0] k;       // s*s - u.u, 60 fraction bits
    logic signed [66:0] two_d;   // 2(u.v), 46 fraction bits
    logic signed [32:0] two_s;   // 2s, 30 fraction bits
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } mid_t;

  // per-component partial sums, 76 fraction bits once recombined
  typedef struct packed {
    logic [2:0][67:0] lsum;      // low partials plus rounding half
    logic [2:0][69:0] hsum;      // high partials, weight 2^32
  } part_t;

  // half an output lsb at 76 fraction bits
  localparam logic signed [67:0] RoundHalf = 68'h0_0800_0000_0000_0000;

  // low limb of the wide operand times the narrow operand
  function automatic logic signed [65:0] mul_lo(input logic signed [66:0] w,
                                                input logic signed [32:0] n);
    logic signed [32:0] wl;
    wl = $signed({1'b0, w[31:0]});
    return wl * n;
  endfunction

  // high limb of the wide operand times the narrow operand
  function automatic logic signed [67:0] mul_hi(input logic signed [66:0] w,
                                                input logic signed [32:0] n);
    logic signed [34:0] wh;
    wh = $signed(w[66:32]);
    return wh * n;
  endfunction

endpackage

### design/quaternion_vector_rotate_core.sv
// Rotates a Q16.16 vector by a Q2.30 quaternion (not normalised, so a non-unit
// quaternion also scales) and returns the vector rounded to nearest, ties up,
// and saturated to Q16.16. One request is taken every clock while the output
// side is not stalled. The six register stages are: the 32x32 products, the
// cross/dot products and scale terms, the split second-level multiplies, the
// limb sums, the final wide add with rounding, and the saturating output
// register. Stalls back up stage by stage, so empty stages keep taking
// requests while a result waits.
module quaternion_vector_rotate_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w, 32 bits each
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, 32 bits each
  output logic [95:0]  out_tdata
);
  import qvr_pkg::*;

  in_t   in_req;
  mid_t  mid;
  part_t part;
  logic  mid_valid, mid_ready, part_valid, part_ready;

  // unpack the request
  always_comb begin
    in_req.vec_x  = $signed(in_tdata[31:0]);
    in_req.vec_y  = $signed(in_tdata[63:32]);
    in_req.vec_z  = $signed(in_tdata[95:64]);
    in_req.quat_x = $signed(in_tdata[127:96]);
    in_req.quat_y = $signed(in_tdata[159:128]);
    in_req.quat_z = $signed(in_tdata[191:160]);
    in_req.quat_w = $signed(in_tdata[223:192]);
  end

  qvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_req),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid)
  );

  qvr_wide u_wide (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid),
    .dn_valid (part_valid),
    .dn_ready (part_ready),
    .dn_data  (part)
  );

  qvr_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (part_valid),
    .up_ready (part_ready),
    .up_data  (part),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

endmodule

### design/qvr_front.sv
module qvr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  qvr_pkg::in_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output qvr_pkg::mid_t dn_data
);
  import qvr_pkg::*;

  logic  vld1_r, vld1_nxt, vld2_r, vld2_nxt;
  logic  rdy1, rdy2;
  in_t   in1_r;
  mid_t  mid_nxt, mid_r;
  logic signed [63:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [63:0] p_xx_r, p_yy_r, p_zz_r;
  logic signed [63:0] q_xx_r, q_yy_r, q_zz_r, q_ww_r;
  logic signed [65:0] dqv;

  // stage readiness, a stage moves when empty or when the next one moves
  assign rdy2     = !vld2_r || dn_ready;
  assign rdy1     = !vld1_r || rdy2;
  assign up_ready = rdy1;
  assign vld1_nxt = rdy1 ? up_valid : vld1_r;
  assign vld2_nxt = rdy2 ? vld1_r : vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld1_nxt;
      vld2_r <= vld2_nxt;
    end
  end

  // stage 1: all 32x32 products
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      in1_r  <= up_data;
      p_yz_r <= up_data.quat_y * up_data.vec_z;
      p_zy_r <= up_data.quat_z * up_data.vec_y;
      p_zx_r <= up_data.quat_z * up_data.vec_x;
      p_xz_r <= up_data.quat_x * up_data.vec_z;
      p_xy_r <= up_data.quat_x * up_data.vec_y;
      p_yx_r <= up_data.quat_y * up_data.vec_x;
      p_xx_r <= up_data.quat_x * up_data.vec_x;
      p_yy_r <= up_data.quat_y * up_data.vec_y;
      p_zz_r <= up_data.quat_z * up_data.vec_z;
      q_xx_r <= up_data.quat_x * up_data.quat_x;
      q_yy_r <= up_data.quat_y * up_data.quat_y;
      q_zz_r <= up_data.quat_z * up_data.quat_z;
      q_ww_r <= up_data.quat_w * up_data.quat_w;
    end
  end

  // stage 2: cross product, dot products and scale factors
  always_comb begin
    dqv           = 66'(p_xx_r) + 66'(p_yy_r) + 66'(p_zz_r);
    mid_nxt.c_x   = 65'(p_yz_r) - 65'(p_zy_r);
    mid_nxt.c_y   = 65'(p_zx_r) - 65'(p_xz_r);
    mid_nxt.c_z   = 65'(p_xy_r) - 65'(p_yx_r);
    mid_nxt.k     = 66'(q_ww_r) - 66'(q_xx_r) - 66'(q_yy_r) - 66'(q_zz_r);
    mid_nxt.two_d = $signed({dqv, 1'b0});
    mid_nxt.two_s = $signed({in1_r.quat_w, 1'b0});
    mid_nxt.vec_x  = in1_r.vec_x;
    mid_nxt.vec_y  = in1_r.vec_y;
    mid_nxt.vec_z  = in1_r.vec_z;
    mid_nxt.quat_x = in1_r.quat_x;
    mid_nxt.quat_y = in1_r.quat_y;
    mid_nxt.quat_z = in1_r.quat_z;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && vld1_r) begin
      mid_r <= mid_nxt;
    end
  end

  assign dn_valid = vld2_r;
  assign dn_data  = mid_r;

endmodule

### design/qvr_wide.sv
module qvr_wide (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  qvr_pkg::mid_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output qvr_pkg::part_t dn_data
);
  import qvr_pkg::*;

  logic  vld3_r, vld3_nxt, vld4_r, vld4_nxt;
  logic  rdy3, rdy4;
  logic signed [66:0] w_op [3][3];
  logic signed [32:0] n_op [3][3];
  logic signed [65:0] lo_r [3][3];
  logic signed [67:0] hi_r [3][3];
  part_t part_nxt, part_r;

  assign rdy4     = !vld4_r || dn_ready;
  assign rdy3     = !vld3_r || rdy4;
  assign up_ready = rdy3;
  assign vld3_nxt = rdy3 ? up_valid : vld3_r;
  assign vld4_nxt = rdy4 ? vld3_r : vld4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= vld3_nxt;
      vld4_r <= vld4_nxt;
    end
  end

  // operand pairs per component: 2s*c, k*v, 2d*u
  always_comb begin
    w_op[0][0] = 67'(up_data.c_x);
    w_op[1][0] = 67'(up_data.c_y);
    w_op[2][0] = 67'(up_data.c_z);
    w_op[0][1] = 67'(up_data.k);
    w_op[1][1] = 67'(up_data.k);
    w_op[2][1] = 67'(up_data.k);
    w_op[0][2] = up_data.two_d;
    w_op[1][2] = up_data.two_d;
    w_op[2][2] = up_data.two_d;
    n_op[0][0] = up_data.two_s;
    n_op[1][0] = up_data.two_s;
    n_op[2][0] = up_data.two_s;
    n_op[0][1] = 33'(up_data.vec_x);
    n_op[1][1] = 33'(up_data.vec_y);
    n_op[2][1] = 33'(up_data.vec_z);
    n_op[0][2] = 33'(up_data.quat_x);
    n_op[1][2] = 33'(up_data.quat_y);
    n_op[2][2] = 33'(up_data.quat_z);
  end

  // stage 3: wide products split into two limbs each
  always_ff @(posedge clk) begin
    if (rdy3 && up_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          lo_r[i][j] <= mul_lo(w_op[i][j], n_op[i][j]);
          hi_r[i][j] <= mul_hi(w_op[i][j], n_op[i][j]);
        end
      end
    end
  end

  // stage 4: sum limbs of like weight, fold in the rounding half
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      part_nxt.lsum[i] = 68'(lo_r[i][0]) + 68'(lo_r[i][1]) + 68'(lo_r[i][2]) + RoundHalf;
      part_nxt.hsum[i] = 70'(hi_r[i][0]) + 70'(hi_r[i][1]) + 70'(hi_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && vld3_r) begin
      part_r <= part_nxt;
    end
  end

  assign dn_valid = vld4_r;
  assign dn_data  = part_r;

endmodule

### design/qvr_round.sv
module qvr_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  qvr_pkg::part_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output logic [95:0]    dn_data
);
  import qvr_pkg::*;

  logic  vld5_r, vld5_nxt, vld6_r, vld6_nxt;
  logic  rdy5, rdy6;
  logic signed [103:0] tot [3];
  logic signed [43:0]  rnd_r [3];
  logic [2:0][31:0]    sat_nxt, res_r;

  assign rdy6     = !vld6_r || dn_ready;
  assign rdy5     = !vld5_r || rdy6;
  assign up_ready = rdy5;
  assign vld5_nxt = rdy5 ? up_valid : vld5_r;
  assign vld6_nxt = rdy6 ? vld5_r : vld6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld5_r <= vld5_nxt;
      vld6_r <= vld6_nxt;
    end
  end

  // stage 5: recombine limbs, keep the rounded value at 16 fraction bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (104'($signed(up_data.hsum[i])) <<< 32) + 104'($signed(up_data.lsum[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && up_valid) begin
      for (int i = 0; i < 3; i++) begin
        rnd_r[i] <= tot[i][103:60];
      end
    end
  end

  // stage 6: clamp to the 32-bit signed range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (rnd_r[i][43:31] == '0 || rnd_r[i][43:31] == '1) begin
        sat_nxt[i] = rnd_r[i][31:0];
      end else if (rnd_r[i][43]) begin
        sat_nxt[i] = 32'h8000_0000;
      end else begin
        sat_nxt[i] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && vld5_r) begin
      res_r <= sat_nxt;
    end
  end

  assign dn_valid = vld6_r;
  assign dn_data  = res_r;

endmodule

### design/qvr_checker.sv
`include "quaternion_vector_rotate_core_macros.svh"

module qvr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);

  // nothing comes out straight after reset
  `QVR_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), !out_tvalid)

  // a stalled result holds
  `QVR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // input back-pressure only when the output itself is stalled
  `QVR_ASSERT_IMP(a_bp_source, !in_tready, out_tvalid && !out_tready)

  // a result taken frees the whole pipe for a new request
  `QVR_ASSERT_IMP(a_drain_ready, out_tvalid && out_tready, in_tready)

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
